// File: src/rdc_pkg.sv
// Shared constants, types and a helper function for the radix digit converter.
`default_nettype none
package rdc_pkg;

	localparam int VALUE_BITS     = 31;
	localparam int RADIX_BITS     = 5;
	localparam int DIGIT_BITS     = 4;
	localparam int CHAR_BITS      = 7;
	localparam int STACK_DEPTH    = 32;
	localparam int CNT_BITS       = $clog2(STACK_DEPTH + 1);
	localparam int PTR_BITS       = $clog2(STACK_DEPTH);
	localparam int STEP_BITS      = $clog2(VALUE_BITS);
	localparam int RADIX_MIN      = 2;
	localparam int RADIX_MAX      = 16;
	localparam int IN_FIELD_BITS  = VALUE_BITS + RADIX_BITS;
	localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = DIGIT_BITS + CHAR_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_A    = 7'h41;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_POP,
		S_LOAD,
		S_BAD
	} state_t;

	typedef struct packed {
		logic                  start;
		logic                  reload;
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_BITS-1:0] radix;
	} div_ctrl_t;

	typedef struct packed {
		logic                  done;
		logic [DIGIT_BITS-1:0] rem;
		logic                  quo_zero;
	} div_stat_t;

	typedef struct packed {
		logic                  clear;
		logic                  push;
		logic                  pop;
		logic [DIGIT_BITS-1:0] data;
	} stk_ctrl_t;

	typedef struct packed {
		logic [DIGIT_BITS-1:0] rd_data;
		logic                  empty;
		logic                  last_slot;
	} stk_stat_t;

	function automatic logic [CHAR_BITS-1:0] char_of(input logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] c;
		if (d < DIGIT_BITS'(10)) begin
			c = CHAR_ZERO + CHAR_BITS'(d);
		end else begin
			c = CHAR_A + CHAR_BITS'(d) - CHAR_BITS'(10);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: src/rdc_divider.sv
// Bit-serial restoring divider that retires one quotient bit per cycle.
`default_nettype none
module rdc_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rdc_pkg::div_ctrl_t ctrl,
	output rdc_pkg::div_stat_t     stat
);

	logic                           run_q;
	logic                           done_q;
	logic [rdc_pkg::STEP_BITS-1:0]  cnt_q;
	logic [rdc_pkg::DIGIT_BITS-1:0] rem_q;
	logic [rdc_pkg::VALUE_BITS-1:0] quo_q;
	logic [rdc_pkg::RADIX_BITS-1:0] div_q;
	logic [rdc_pkg::DIGIT_BITS:0]   trial;
	logic [rdc_pkg::DIGIT_BITS:0]   diff;
	logic                           ge;

	assign trial = {rem_q, quo_q[rdc_pkg::VALUE_BITS-1]};
	assign ge    = trial >= (rdc_pkg::DIGIT_BITS + 1)'(div_q);
	assign diff  = trial - (rdc_pkg::DIGIT_BITS + 1)'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				run_q <= 1'b1;
				cnt_q <= rdc_pkg::STEP_BITS'(rdc_pkg::VALUE_BITS - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			if (ctrl.reload) begin
				quo_q <= ctrl.value;
				div_q <= ctrl.radix;
			end
		end else if (run_q) begin
			rem_q <= ge ? diff[rdc_pkg::DIGIT_BITS-1:0] : trial[rdc_pkg::DIGIT_BITS-1:0];
			quo_q <= {quo_q[rdc_pkg::VALUE_BITS-2:0], ge};
		end
	end

	assign stat.done     = done_q;
	assign stat.rem      = rem_q;
	assign stat.quo_zero = (quo_q == '0);

endmodule
`default_nettype wire

// File: src/rdc_stack.sv
// Digit stack memory with a fill count, one push or one registered pop per cycle.
`default_nettype none
module rdc_stack (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rdc_pkg::stk_ctrl_t ctrl,
	output rdc_pkg::stk_stat_t     stat
);

	logic [rdc_pkg::DIGIT_BITS-1:0] mem [rdc_pkg::STACK_DEPTH];
	logic [rdc_pkg::CNT_BITS-1:0]   count_q;
	logic [rdc_pkg::CNT_BITS-1:0]   top_idx;
	logic [rdc_pkg::DIGIT_BITS-1:0] rd_q;
	logic                           full;

	assign full    = (count_q == rdc_pkg::CNT_BITS'(rdc_pkg::STACK_DEPTH));
	assign top_idx = count_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.push && !full) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop && count_q != '0) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && !full && !ctrl.clear) begin
			mem[count_q[rdc_pkg::PTR_BITS-1:0]] <= ctrl.data;
		end
		if (ctrl.pop) begin
			rd_q <= mem[top_idx[rdc_pkg::PTR_BITS-1:0]];
		end
	end

	assign stat.rd_data   = rd_q;
	assign stat.empty     = (count_q == '0);
	assign stat.last_slot = (count_q == rdc_pkg::CNT_BITS'(rdc_pkg::STACK_DEPTH - 1));

endmodule
`default_nettype wire

// File: src/radix_digit_converter.sv
// Top level of the radix digit converter: control sequencer and output register.
//
// An input item on the s_axis channel carries a value and a radix. The block
// divides the value by the radix over and over with a bit-serial divider and
// stacks each remainder, then sends the digits on m_axis most significant
// first, one item per digit, with tlast on the final digit. A zero value gives
// the single digit 0. A radix outside 2 to 16 gives one item with tuser set,
// tlast set and zero data.
// The divider retires one quotient bit per cycle over all VALUE_BITS bits of a
// digit, then the remainder is pushed, and each digit leaves the stack through
// a registered memory read, then an output load. The next input item can be
// accepted once the last digit is loaded into the output register. A bad
// radix item passes through the S_BAD state into the output register.
// s_axis_tready is high only while no conversion is in progress.
// When the receiver stalls, the output register holds its item and the
// sequencer waits; no digit is lost. Reset clears the sequencer, the stack
// count and the output valid flag, and the block is then ready at once.
`default_nettype none
module radix_digit_converter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// value [30:0], radix [35:31], zero fill above
	input  wire logic [rdc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// digit_value [3:0], digit_char [10:4], zero fill above
	output logic [rdc_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,
	output logic                                    m_axis_tlast,
	// bad_radix [0]
	output logic                                    m_axis_tuser
);

	rdc_pkg::state_t    state_q;
	rdc_pkg::state_t    state_d;
	rdc_pkg::div_ctrl_t div_ctrl;
	rdc_pkg::div_stat_t div_stat;
	rdc_pkg::stk_ctrl_t stk_ctrl;
	rdc_pkg::stk_stat_t stk_stat;

	logic [rdc_pkg::VALUE_BITS-1:0] in_value;
	logic [rdc_pkg::RADIX_BITS-1:0] in_radix;
	logic                           radix_bad;
	logic                           out_free;
	logic                           out_load;
	logic [rdc_pkg::DIGIT_BITS-1:0] out_dv_d;
	logic                           out_last_d;
	logic                           out_bad_d;

	logic                           out_valid_q;
	logic [rdc_pkg::DIGIT_BITS-1:0] out_dv_q;
	logic [rdc_pkg::CHAR_BITS-1:0]  out_char_q;
	logic                           out_last_q;
	logic                           out_bad_q;

	assign in_value  = s_axis_tdata[rdc_pkg::VALUE_BITS-1:0];
	assign in_radix  = s_axis_tdata[rdc_pkg::IN_FIELD_BITS-1:rdc_pkg::VALUE_BITS];
	assign radix_bad = (in_radix < rdc_pkg::RADIX_BITS'(rdc_pkg::RADIX_MIN)) ||
		(in_radix > rdc_pkg::RADIX_BITS'(rdc_pkg::RADIX_MAX));
	assign out_free  = !out_valid_q || m_axis_tready;

	rdc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.stat   (div_stat)
	);

	rdc_stack u_stk (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (stk_ctrl),
		.stat   (stk_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		s_axis_tready   = 1'b0;
		div_ctrl.start  = 1'b0;
		div_ctrl.reload = 1'b0;
		div_ctrl.value  = in_value;
		div_ctrl.radix  = in_radix;
		stk_ctrl.clear  = 1'b0;
		stk_ctrl.push   = 1'b0;
		stk_ctrl.pop    = 1'b0;
		stk_ctrl.data   = div_stat.rem;
		out_load        = 1'b0;
		out_dv_d        = stk_stat.rd_data;
		out_last_d      = stk_stat.empty;
		out_bad_d       = 1'b0;
		case (state_q)
			rdc_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (radix_bad) begin
						state_d = rdc_pkg::S_BAD;
					end else begin
						div_ctrl.start  = 1'b1;
						div_ctrl.reload = 1'b1;
						stk_ctrl.clear  = 1'b1;
						state_d         = rdc_pkg::S_DIV;
					end
				end
			end
			rdc_pkg::S_DIV: begin
				if (div_stat.done) begin
					stk_ctrl.push = 1'b1;
					if (div_stat.quo_zero || stk_stat.last_slot) begin
						state_d = rdc_pkg::S_POP;
					end else begin
						div_ctrl.start = 1'b1;
					end
				end
			end
			rdc_pkg::S_POP: begin
				stk_ctrl.pop = 1'b1;
				state_d      = rdc_pkg::S_LOAD;
			end
			rdc_pkg::S_LOAD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = stk_stat.empty ? rdc_pkg::S_IDLE : rdc_pkg::S_POP;
				end
			end
			rdc_pkg::S_BAD: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_dv_d   = '0;
					out_last_d = 1'b1;
					out_bad_d  = 1'b1;
					state_d    = rdc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rdc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dv_q   <= out_dv_d;
			out_char_q <= out_bad_d ? '0 : rdc_pkg::char_of(out_dv_d);
			out_last_q <= out_last_d;
			out_bad_q  <= out_bad_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(rdc_pkg::OUT_TDATA_BITS - rdc_pkg::OUT_FIELD_BITS)'(0),
		out_char_q, out_dv_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_bad_q;

endmodule
`default_nettype wire

// File: src/rdc_checker.sv
// Port-level checker for the radix digit converter and its bind statement.
`default_nettype none
module rdc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic [rdc_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [rdc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	input wire logic                              m_axis_tlast,
	input wire logic                              m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled output item changed");

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
		else $error("bad radix item is not a single zero item");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			(m_axis_tdata[3:0] < 4'd10 &&
				m_axis_tdata[10:4] == 7'd48 + {3'd0, m_axis_tdata[3:0]}) ||
			(m_axis_tdata[3:0] >= 4'd10 &&
				m_axis_tdata[10:4] == 7'd55 + {3'd0, m_axis_tdata[3:0]}))
		else $error("digit character does not match digit value");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a conversion is in progress");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
`default_nettype wire

// File: tb/sv/radix_digit_converter_tb.sv
// Self-checking testbench for the radix digit converter stream block.
`default_nettype none
module radix_digit_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [rdc_pkg::DIGIT_BITS-1:0] digit;
		logic [rdc_pkg::CHAR_BITS-1:0]  glyph;
		logic                           last;
		logic                           bad;
	} digit_item_t;

	class radix_digit_tracker;
		digit_item_t pending_digits[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		function void note_conversion(logic [rdc_pkg::VALUE_BITS-1:0] value,
			logic [rdc_pkg::RADIX_BITS-1:0] radix);
			logic [rdc_pkg::DIGIT_BITS-1:0] digits[$];
			logic [rdc_pkg::VALUE_BITS-1:0] quo;
			digit_item_t                    e;
			if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
				e.digit = '0;
				e.glyph = '0;
				e.last  = 1'b1;
				e.bad   = 1'b1;
				pending_digits.push_back(e);
				return;
			end
			quo = value;
			do begin
				digits.push_front(rdc_pkg::DIGIT_BITS'(quo % radix));
				quo = quo / radix;
			end while (quo != 0);
			foreach (digits[i]) begin
				e.digit = digits[i];
				if (digits[i] < 10)
					e.glyph = 7'h30 + rdc_pkg::CHAR_BITS'(digits[i]);
				else
					e.glyph = 7'h41 + rdc_pkg::CHAR_BITS'(digits[i]) - 7'd10;
				e.last = (i == digits.size() - 1);
				e.bad  = 1'b0;
				pending_digits.push_back(e);
			end
		endfunction

		function void check_digit(logic [rdc_pkg::OUT_TDATA_BITS-1:0] tdata, logic tlast,
			logic tuser);
			digit_item_t e;
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected item tdata=%h tlast=%b tuser=%b",
					$realtime, tdata, tlast, tuser);
				errors++;
				return;
			end
			e = pending_digits.pop_front();
			if (tdata[rdc_pkg::DIGIT_BITS-1:0] !== e.digit) begin
				$display("%0t: digit_value expected %h actual %h",
					$realtime, e.digit, tdata[rdc_pkg::DIGIT_BITS-1:0]);
				errors++;
			end
			if (tdata[rdc_pkg::DIGIT_BITS +: rdc_pkg::CHAR_BITS] !== e.glyph) begin
				$display("%0t: digit_char expected %h actual %h",
					$realtime, e.glyph, tdata[rdc_pkg::DIGIT_BITS +: rdc_pkg::CHAR_BITS]);
				errors++;
			end
			if (tlast !== e.last) begin
				$display("%0t: last_digit expected %b actual %b", $realtime, e.last, tlast);
				errors++;
			end
			if (tuser !== e.bad) begin
				$display("%0t: bad_radix expected %b actual %b", $realtime, e.bad, tuser);
				errors++;
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [rdc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [rdc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic                               m_axis_tlast;
	logic                               m_axis_tuser;

	radix_digit_tracker tracker;
	bit                 tx_quiet;
	bit                 rx_quiet;

	radix_digit_converter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int draw_gap(ref bit quiet);
		if ($urandom_range(0, 19) == 0)
			quiet = ~quiet;
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic send_conversion(logic [rdc_pkg::VALUE_BITS-1:0] value,
		logic [rdc_pkg::RADIX_BITS-1:0] radix);
		int gap;
		gap = draw_gap(tx_quiet);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(rdc_pkg::IN_TDATA_BITS - rdc_pkg::IN_FIELD_BITS){1'b0}},
			radix, value};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_conversion(value, radix);
	endtask

	task automatic send_random_conversion();
		logic [rdc_pkg::VALUE_BITS-1:0] value;
		logic [rdc_pkg::RADIX_BITS-1:0] radix;
		int                             width;
		int                             k;
		width = $urandom_range(0, 1) ? rdc_pkg::VALUE_BITS :
			$urandom_range(0, rdc_pkg::VALUE_BITS);
		value = rdc_pkg::VALUE_BITS'($urandom);
		if (width < rdc_pkg::VALUE_BITS)
			value &= (rdc_pkg::VALUE_BITS'(1) << width) - rdc_pkg::VALUE_BITS'(1);
		if ($urandom_range(0, 9) < 8) begin
			radix = rdc_pkg::RADIX_BITS'($urandom_range(rdc_pkg::RADIX_MIN, rdc_pkg::RADIX_MAX));
		end else begin
			k = $urandom_range(0, 16);
			radix = (k < 2) ? rdc_pkg::RADIX_BITS'(k) :
				rdc_pkg::RADIX_BITS'(rdc_pkg::RADIX_MAX + k - 1);
		end
		send_conversion(value, radix);
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(rx_quiet);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.check_digit(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	initial begin
		int guard;
		tracker       = new();
		tx_quiet      = 1'b0;
		rx_quiet      = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_conversion('0, 5'd10);
		send_conversion('0, 5'd2);
		send_conversion(31'd1, 5'd2);
		send_conversion(31'd9, 5'd10);
		for (int r = rdc_pkg::RADIX_MIN; r <= rdc_pkg::RADIX_MAX; r++)
			send_conversion('1, rdc_pkg::RADIX_BITS'(r));
		send_conversion(31'h7EDCBA98, 5'd16);
		send_conversion(31'h55555555, 5'd0);
		send_conversion('0, 5'd1);
		send_conversion(31'h2AAAAAAA, 5'd17);
		send_conversion('1, 5'd31);

		repeat (156) send_random_conversion();
		s_axis_tvalid <= 1'b0;

		guard = 0;
		while (tracker.pending_digits.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);

		if (tracker.errors == 0 && tracker.pending_digits.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
